// ===== hw/rtl/lfu_slot_table_replace_defines.svh =====
// Assertion macros shared by the slot table design.
`ifndef LFU_SLOT_TABLE_REPLACE_DEFINES_SVH
`define LFU_SLOT_TABLE_REPLACE_DEFINES_SVH

// Same-cycle implication, sampled on clock, idle during reset.
`define LFUST_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfu_slot_table_replace: same-cycle check failed");

// Next-cycle implication, sampled on clock, idle during reset.
`define LFUST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfu_slot_table_replace: next-cycle check failed");

`endif

// ===== hw/rtl/lfust_pkg.sv =====
// Types and constants of the LFU slot table.
`timescale 1ns / 1ps
`default_nettype none
package lfust_pkg;

   localparam int ID_W       = 7;
   localparam int COUNT_W    = 16;
   localparam int TIME_W     = 32;
   localparam int CFG_W      = 6;
   localparam int SLOT_OUT_W = 5;

   localparam logic [CFG_W-1:0]   ACTIVE_RESET = 6'd32;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
   localparam logic [TIME_W-1:0]  TIME_MAX     = 32'hFFFF_FFFF;

   // One table entry as held in the slot RAM
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  stamp;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic start;   // latch request, reset scan
      logic issue;   // read next slot
      logic commit;  // write back and load result
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_last;  // slot being issued is the last active one
   } stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/lfust_channels.sv =====
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface lfust_req_if;
   logic                     valid;
   logic                     ready;
   logic [lfust_pkg::ID_W-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface lfust_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [lfust_pkg::SLOT_OUT_W-1:0] slot;
   logic                             evicted_valid;
   logic [lfust_pkg::ID_W-1:0]       evicted_id;
   logic [lfust_pkg::COUNT_W-1:0]    new_count;

   modport source (output valid, output hit, output slot, output evicted_valid,
                   output evicted_id, output new_count, input ready);
   modport sink   (input valid, input hit, input slot, input evicted_valid,
                   input evicted_id, input new_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lfust_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lfust_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                           wdata,
   output      logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lfust_ctrl.sv =====
// Controller: sequences accept, slot scan, write back and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module lfust_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      lfust_pkg::cmd_type  cmd,
   input  wire lfust_pkg::stat_type stat
);
   import lfust_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN,
      COMMIT
   } state_type;

   state_type state_ff;
   logic      out_full_ff;
   logic      can_commit;

   // Result register can take a new result when empty or being drained
   assign can_commit = !out_full_ff || rsp_ready;

   assign req_ready  = (state_ff == IDLE);
   assign rsp_valid  = out_full_ff;
   assign cmd.start  = req_valid && req_ready;
   assign cmd.issue  = (state_ff == SCAN);
   assign cmd.commit = (state_ff == COMMIT) && can_commit;

   // State and result-valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         out_full_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            out_full_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_full_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (cmd.start) begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (stat.scan_last) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               state_ff <= COMMIT;
            end
            COMMIT: begin
               if (can_commit) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lfust_dp.sv =====
// Datapath: slot RAM, valid bits, scan trackers, item counter and result register.
`timescale 1ns / 1ps
`default_nettype none
module lfust_dp #(
   parameter int SLOTS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lfust_pkg::cmd_type                 cmd,
   output      lfust_pkg::stat_type                stat,
   input  wire logic [lfust_pkg::ID_W-1:0]         candidate,
   input  wire logic                               csr_we,
   input  wire logic [lfust_pkg::CFG_W-1:0]        csr_wdata,
   output      logic                               out_hit,
   output      logic [lfust_pkg::SLOT_OUT_W-1:0]   out_slot,
   output      logic                               out_evicted_valid,
   output      logic [lfust_pkg::ID_W-1:0]         out_evicted_id,
   output      logic [lfust_pkg::COUNT_W-1:0]      out_new_count
);
   import lfust_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Configuration and request context
   logic [CFG_W-1:0]  active_ff;
   logic [6:0]        cfg_ext;
   logic [6:0]        used;
   logic [SLOT_W-1:0] last_idx_ff;
   logic [ID_W-1:0]   want_ff;
   logic [TIME_W-1:0] item_cnt_ff;
   logic [TIME_W-1:0] now_ff;

   // Scan pipeline
   logic [SLOT_W-1:0] scan_idx_ff;
   logic              data_vld_ff;
   logic [SLOT_W-1:0] data_idx_ff;
   logic [SLOTS-1:0]  valid_ff;
   entry_type         rd_entry;
   logic              rd_valid;

   // Trackers
   logic               found_ff;
   logic [SLOT_W-1:0]  hit_idx_ff;
   logic [COUNT_W-1:0] hit_count_ff;
   logic [TIME_W-1:0]  hit_time_ff;
   logic               empty_ff;
   logic [SLOT_W-1:0]  empty_idx_ff;
   logic               best_set_ff;
   logic [SLOT_W-1:0]  best_idx_ff;
   logic [COUNT_W-1:0] best_count_ff;
   logic [TIME_W-1:0]  best_time_ff;
   logic [ID_W-1:0]    best_id_ff;
   logic               better;

   // Write back
   logic               evict;
   logic [SLOT_W-1:0]  target;
   logic [COUNT_W-1:0] hit_count_inc;
   entry_type          wr_entry;
   logic [SLOT_W-1:0]  ram_addr;

   // Clamp active slot count to 1..SLOTS, keep the last index
   assign cfg_ext = {1'b0, active_ff};
   always_comb begin
      priority if (cfg_ext == 7'd0) begin
         used = 7'd1;
      end else if (cfg_ext > 7'(SLOTS)) begin
         used = 7'(SLOTS);
      end else begin
         used = cfg_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_we) begin
         active_ff <= csr_wdata;
      end
   end

   // Request latch and saturating item counter
   always_ff @(posedge clock) begin
      if (reset) begin
         item_cnt_ff <= '0;
      end else if (cmd.start && item_cnt_ff != TIME_MAX) begin
         item_cnt_ff <= item_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         want_ff     <= candidate;
         now_ff      <= item_cnt_ff;
         last_idx_ff <= SLOT_W'(used - 7'd1);
      end
   end

   // Scan address and read-data tag
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         data_vld_ff <= 1'b0;
         data_idx_ff <= '0;
      end else begin
         data_vld_ff <= cmd.issue;
         data_idx_ff <= scan_idx_ff;
         if (cmd.start) begin
            scan_idx_ff <= '0;
         end else if (cmd.issue) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
      end
   end

   assign stat.scan_last = (scan_idx_ff == last_idx_ff);

   // Slot storage
   assign ram_addr = cmd.commit ? target : scan_idx_ff;

   lfust_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (cmd.commit),
      .addr  (ram_addr),
      .wdata (wr_entry),
      .rdata (rd_entry)
   );

   assign rd_valid = valid_ff[data_idx_ff];

   // Victim order: least count, then oldest insertion, then lowest index
   assign better = !best_set_ff || (rd_entry.count < best_count_ff) ||
                   (rd_entry.count == best_count_ff && rd_entry.stamp < best_time_ff);

   // Hit, first empty and victim trackers
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         empty_ff    <= 1'b0;
         best_set_ff <= 1'b0;
      end else if (cmd.start) begin
         found_ff    <= 1'b0;
         empty_ff    <= 1'b0;
         best_set_ff <= 1'b0;
      end else if (data_vld_ff) begin
         if (rd_valid && !found_ff && rd_entry.id == want_ff) begin
            found_ff <= 1'b1;
         end
         if (!rd_valid && !empty_ff) begin
            empty_ff <= 1'b1;
         end
         if (rd_valid && better) begin
            best_set_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (data_vld_ff) begin
         if (rd_valid && !found_ff && rd_entry.id == want_ff) begin
            hit_idx_ff   <= data_idx_ff;
            hit_count_ff <= rd_entry.count;
            hit_time_ff  <= rd_entry.stamp;
         end
         if (!rd_valid && !empty_ff) begin
            empty_idx_ff <= data_idx_ff;
         end
         if (rd_valid && better) begin
            best_idx_ff   <= data_idx_ff;
            best_count_ff <= rd_entry.count;
            best_time_ff  <= rd_entry.stamp;
            best_id_ff    <= rd_entry.id;
         end
      end
   end

   // Target slot and entry to write back
   assign evict         = !found_ff && !empty_ff;
   assign hit_count_inc = (hit_count_ff == COUNT_MAX) ? COUNT_MAX : hit_count_ff + 1'b1;

   always_comb begin
      priority if (found_ff) begin
         target         = hit_idx_ff;
         wr_entry.id    = want_ff;
         wr_entry.count = hit_count_inc;
         wr_entry.stamp = hit_time_ff;
      end else if (empty_ff) begin
         target         = empty_idx_ff;
         wr_entry.id    = want_ff;
         wr_entry.count = COUNT_W'(1);
         wr_entry.stamp = now_ff;
      end else begin
         target         = best_idx_ff;
         wr_entry.id    = want_ff;
         wr_entry.count = COUNT_W'(1);
         wr_entry.stamp = now_ff;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[target] <= 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_hit           <= found_ff;
         out_slot          <= SLOT_OUT_W'(target);
         out_evicted_valid <= evict;
         out_evicted_id    <= evict ? best_id_ff : '0;
         out_new_count     <= found_ff ? hit_count_inc : COUNT_W'(1);
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lfu_slot_table_replace.sv =====
// Top level of the LFU slot table with oldest-insertion tie break.
//
// Usage:
//   req_chan carries one candidate id per transaction (valid/ready). rsp_chan
//   returns one result per request: hit flag, slot now holding the id, the
//   evicted id if any, and the id's reference count after the request.
//   csr_we/csr_wdata write the active slot count; write only while idle.
// Timing:
//   A request is taken when idle, then the active slots (clamped to 1..SLOTS)
//   are read from the slot RAM one per cycle through its single port, then a
//   drain step and a write-back step follow.
//   The result appears on rsp_chan in the cycle after the write back.
// Stalls:
//   The result sits in an output register, so the next request is taken and
//   scanned while a result waits. Write back waits until that register frees.
// Reset:
//   Synchronous, active high. Clears all slot valid bits, the item counter and
//   the control state; active slot count returns to 32. RAM contents need no
//   clearing since unoccupied slots are never read as data.
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_slot_table_replace_defines.svh"
module lfu_slot_table_replace #(
   parameter int SLOTS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   lfust_req_if.sink                        req_chan,
   lfust_rsp_if.source                      rsp_chan,
   input  wire logic                        csr_we,
   input  wire logic [lfust_pkg::CFG_W-1:0] csr_wdata
);
   import lfust_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lfust_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   lfust_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .candidate         (req_chan.candidate),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .out_hit           (rsp_chan.hit),
      .out_slot          (rsp_chan.slot),
      .out_evicted_valid (rsp_chan.evicted_valid),
      .out_evicted_id    (rsp_chan.evicted_id),
      .out_new_count     (rsp_chan.new_count)
   );

   // Checks
   `LFUST_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready)
   `LFUST_ASSERT_NOW(a_hit_no_evict, rsp_chan.valid && rsp_chan.hit, !rsp_chan.evicted_valid)
   `LFUST_ASSERT_NOW(a_no_evict_zero_id, rsp_chan.valid && !rsp_chan.evicted_valid, rsp_chan.evicted_id == '0)
   `LFUST_ASSERT_NOW(a_miss_count_one, rsp_chan.valid && !rsp_chan.hit, rsp_chan.new_count == COUNT_W'(1))
endmodule
`default_nettype wire

// ===== test/lfu_slot_table_replace_tb.sv =====
// Self-checking testbench for the LFU slot table: random traffic, predictor and scoreboard.
`timescale 1ns / 1ps
module lfu_slot_table_replace_tb;
   import lfust_pkg::*;

   localparam int TABLE_SLOTS    = 32;
   localparam int IDLE_PCT       = 20;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 180;
   localparam int REPEAT_ITEMS   = 20;
   localparam int DRAIN_CYCLES   = 40;
   localparam logic [ID_W-1:0] REPEAT_ID = 7'd93;

   // One response transaction as predicted
   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  evicted_valid;
      logic [ID_W-1:0]       evicted_id;
      logic [COUNT_W-1:0]    new_count;
   } lookup_outcome_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [CFG_W-1:0]    csr_wdata;

   lfust_req_if req_chan ();
   lfust_rsp_if rsp_chan ();

   lfu_slot_table_replace #(
      .SLOTS(TABLE_SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor state: shadow copy of the slot table
   logic               tbl_valid [TABLE_SLOTS];
   logic [ID_W-1:0]    tbl_id    [TABLE_SLOTS];
   logic [COUNT_W-1:0] tbl_count [TABLE_SLOTS];
   logic [TIME_W-1:0]  tbl_stamp [TABLE_SLOTS];
   logic [TIME_W-1:0]  request_number;
   logic [CFG_W-1:0]   active_cfg;

   logic [ID_W-1:0]    pending_ids [$];
   lookup_outcome_type expected_outcomes [$];

   bit offered;
   bit req_taken;
   bit no_idle;
   bit want_hold;
   int hold_left;
   int quiet_cycles;
   int errors;

   function automatic int slots_in_use(input logic [CFG_W-1:0] cfg);
      if (cfg == '0)
         return 1;
      if (cfg > CFG_W'(TABLE_SLOTS))
         return TABLE_SLOTS;
      return int'(cfg);
   endfunction

   // Hit search, then lowest empty slot, then least count / oldest insert victim
   function automatic lookup_outcome_type lfu_lookup(input logic [ID_W-1:0] id);
      lookup_outcome_type r;
      int                 used;
      int                 target;
      int                 best;
      bit                 found;
      bit                 have_empty;
      logic [TIME_W-1:0]  now;
      used = slots_in_use(active_cfg);
      now = request_number;
      if (request_number != TIME_MAX)
         request_number++;
      r = '0;
      found = 1'b0;
      target = 0;
      for (int i = 0; i < used; i++) begin
         if (!found && tbl_valid[i] && tbl_id[i] == id) begin
            found = 1'b1;
            target = i;
         end
      end
      if (found) begin
         if (tbl_count[target] != COUNT_MAX)
            tbl_count[target]++;
         r.hit = 1'b1;
         r.slot = SLOT_OUT_W'(target);
         r.new_count = tbl_count[target];
         return r;
      end
      have_empty = 1'b0;
      for (int i = 0; i < used; i++) begin
         if (!have_empty && !tbl_valid[i]) begin
            have_empty = 1'b1;
            target = i;
         end
      end
      if (!have_empty) begin
         best = 0;
         for (int i = 1; i < used; i++) begin
            if (tbl_count[i] < tbl_count[best] ||
                (tbl_count[i] == tbl_count[best] && tbl_stamp[i] < tbl_stamp[best]))
               best = i;
         end
         target = best;
         r.evicted_valid = 1'b1;
         r.evicted_id = tbl_id[best];
      end
      tbl_valid[target] = 1'b1;
      tbl_id[target] = id;
      tbl_count[target] = COUNT_W'(1);
      tbl_stamp[target] = now;
      r.slot = SLOT_OUT_W'(target);
      r.new_count = COUNT_W'(1);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                              input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // Request driver: one transaction held until accepted, random gaps between
   always @(negedge clock) begin
      if (req_taken) begin
         offered = 1'b0;
         req_taken = 1'b0;
      end
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!offered && pending_ids.size() != 0 &&
                   (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
         req_chan.candidate <= pending_ids.pop_front();
         req_chan.valid <= 1'b1;
         offered = 1'b1;
      end else if (!offered) begin
         req_chan.valid <= 1'b0;
      end
   end

   // Response sink: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (want_hold) begin
         want_hold = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Monitor: check responses, predict accepted requests, watchdog
   always @(posedge clock) begin
      lookup_outcome_type want;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            quiet_cycles = 0;
            if (expected_outcomes.size() == 0) begin
               $error("response transaction with no request outstanding");
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("hit", COUNT_W'(want.hit), COUNT_W'(rsp_chan.hit));
               check_field("slot", COUNT_W'(want.slot), COUNT_W'(rsp_chan.slot));
               check_field("evicted_valid", COUNT_W'(want.evicted_valid),
                           COUNT_W'(rsp_chan.evicted_valid));
               check_field("evicted_id", COUNT_W'(want.evicted_id),
                           COUNT_W'(rsp_chan.evicted_id));
               check_field("new_count", want.new_count, rsp_chan.new_count);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            quiet_cycles = 0;
            expected_outcomes.push_back(lfu_lookup(req_chan.candidate));
            req_taken = 1'b1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_ids.size() != 0 || offered || expected_outcomes.size() != 0);
   endtask

   // Register write only once the table has drained
   task automatic set_active_slots(input logic [CFG_W-1:0] value);
      wait_idle();
      repeat (4) @(negedge clock);
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      active_cfg = value;
   endtask

   // Ids drawn mostly from a pool a bit larger than the table, skewed so
   // counts differ, with some fully random ids as noise
   task automatic queue_random_requests(input int count);
      int              used;
      int              span;
      int              base;
      int              pick;
      logic [ID_W-1:0] id;
      used = slots_in_use(active_cfg);
      span = used + $urandom_range(1, used + 2);
      base = $urandom_range(0, 127);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 10)
            id = ID_W'($urandom_range(0, 127));
         else if (pick < 55)
            id = ID_W'((base + $urandom_range(0, span / 2)) % 128);
         else
            id = ID_W'((base + $urandom_range(0, span - 1)) % 128);
         pending_ids.push_back(id);
      end
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] phase_cfg [9];
      logic [CFG_W-1:0] cfg;
      phase_cfg = '{6'd8, 6'd32, 6'd1, 6'd63, 6'd0, 6'd33, 6'd2, 6'd17, 6'd31};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      foreach (tbl_valid[i]) begin
         tbl_valid[i] = 1'b0;
         tbl_id[i] = '0;
         tbl_count[i] = '0;
         tbl_stamp[i] = '0;
      end
      request_number = '0;
      active_cfg = ACTIVE_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: id extremes, hits, alternating bit patterns at reset config
      pending_ids = '{7'd0, 7'd127, 7'd0, 7'd127, 7'd127, 7'd85, 7'd42, 7'd1};
      // Tiny table: fill, then evict by least count with an insertion-age tie break
      set_active_slots(6'd3);
      pending_ids = '{7'd10, 7'd11, 7'd10, 7'd12, 7'd13};

      // Random phases over small, full, zero and oversized settings
      for (int p = 0; p < 9; p++) begin
         cfg = (p == 7) ? CFG_W'($urandom_range(0, 63)) : phase_cfg[p];
         set_active_slots(cfg);
         no_idle = (p == 3);
         if (p == 1)
            want_hold = 1'b1;
         queue_random_requests(PHASE_ITEMS);
      end

      // One slot hammered with a single id: a replace, then repeated hits
      set_active_slots(6'd1);
      no_idle = 1'b0;
      for (int n = 0; n < REPEAT_ITEMS; n++)
         pending_ids.push_back(REPEAT_ID);

      // Grow back: old contents beyond the single slot reappear
      set_active_slots(6'd6);
      queue_random_requests(100);

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && expected_outcomes.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lfust_pkg.sv
hw/rtl/lfust_channels.sv
hw/rtl/lfust_ram.sv
hw/rtl/lfust_ctrl.sv
hw/rtl/lfust_dp.sv
hw/rtl/lfu_slot_table_replace.sv
test/lfu_slot_table_replace_tb.sv
